// ===== hw/rtl/http_request_header_parser_assert.svh =====
// assertion macros for the http request header parser
// used by the top level only, needs clk and rst in scope
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hrp_pkg.sv =====
// shared types and codes for the http request header parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
  localparam int VERSION_OUT_WIDTH = 16;

  typedef enum logic [1:0] {
    S_MORE = 2'd0,
    S_DONE = 2'd1,
    S_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_NONE     = 3'd0,
    K_METHOD   = 3'd1,
    K_URI      = 3'd2,
    K_NEW_NAME = 3'd3,
    K_NAME     = 3'd4,
    K_VALUE    = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    PS_METHOD_START = 5'd0,
    PS_METHOD       = 5'd1,
    PS_URI          = 5'd2,
    PS_H            = 5'd3,
    PS_T1           = 5'd4,
    PS_T2           = 5'd5,
    PS_P            = 5'd6,
    PS_SLASH        = 5'd7,
    PS_MAJOR_START  = 5'd8,
    PS_MAJOR        = 5'd9,
    PS_MINOR_START  = 5'd10,
    PS_MINOR        = 5'd11,
    PS_NL1          = 5'd12,
    PS_LINE_START   = 5'd13,
    PS_LWS          = 5'd14,
    PS_NAME         = 5'd15,
    PS_SPACE_VALUE  = 5'd16,
    PS_VALUE        = 5'd17,
    PS_NL2          = 5'd18,
    PS_NL3          = 5'd19
  } parse_state_t;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic       start;
    logic [7:0] value;
    logic       tok;
    logic       ctl;
    logic       dig;
    logic       sp;
    logic       ws;
    logic       cr;
    logic       lf;
    logic       colon;
    logic       slash;
    logic       dot;
    logic       ch_h;
    logic       ch_t;
    logic       ch_p;
  } byte_class_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hrp_front.sv =====
// front end: takes request bytes and classifies each one for the parser
// depends on hrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrp_front (
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire logic               start_req,
  input  wire logic [7:0]         data_byte,
  input  wire logic               queue_full,
  output logic                    push,
  output hrp_pkg::byte_class_t    entry
);
  import hrp_pkg::*;

  logic ctl;
  logic sep;

  always_comb begin
    ctl = (data_byte <= 8'd31) || (data_byte == 8'd127);
    sep = data_byte inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
                            "/", "[", "]", "?", "=", "{", "}", " "};

    entry.start = start_req;
    entry.value = data_byte;
    entry.ctl   = ctl;
    entry.tok   = !data_byte[7] && !ctl && !sep;
    entry.dig   = data_byte inside {["0":"9"]};
    entry.sp    = data_byte == " ";
    entry.ws    = (data_byte == " ") || (data_byte == 8'h09);
    entry.cr    = data_byte == 8'h0d;
    entry.lf    = data_byte == 8'h0a;
    entry.colon = data_byte == ":";
    entry.slash = data_byte == "/";
    entry.dot   = data_byte == ".";
    entry.ch_h  = data_byte == "H";
    entry.ch_t  = data_byte == "T";
    entry.ch_p  = data_byte == "P";
  end

  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;

endmodule

`default_nettype wire

// ===== hw/rtl/hrp_queue.sv =====
// short queue of classified bytes between front end and parser
// depends on hrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire hrp_pkg::byte_class_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output hrp_pkg::byte_class_t      q_data
);
  import hrp_pkg::*;

  byte_class_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_WIDTH-1:0] wr_ptr;
  logic [QUEUE_PTR_WIDTH-1:0] rd_ptr;
  logic [QUEUE_CNT_WIDTH-1:0] count;

  assign full    = count == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrp_back.sv =====
// back end: request parse state machine, version counters and result register
// depends on hrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrp_back #(
  parameter int VERSION_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire hrp_pkg::byte_class_t q_data,
  output logic                      pop,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [1:0]                status,
  output logic [2:0]                char_kind,
  output logic [7:0]                char_value,
  output logic [hrp_pkg::VERSION_OUT_WIDTH-1:0] version_major,
  output logic [hrp_pkg::VERSION_OUT_WIDTH-1:0] version_minor
);
  import hrp_pkg::*;

  localparam int ACC_WIDTH = VERSION_WIDTH + 4;

  parse_state_t             parse_state;
  parse_state_t             parse_state_next;
  parse_state_t             st_in;
  logic                     header_seen;
  logic                     header_seen_next;
  logic                     hs_in;
  logic [VERSION_WIDTH-1:0] major_count;
  logic [VERSION_WIDTH-1:0] major_next;
  logic [VERSION_WIDTH-1:0] maj_in;
  logic [VERSION_WIDTH-1:0] minor_count;
  logic [VERSION_WIDTH-1:0] minor_next;
  logic [VERSION_WIDTH-1:0] min_in;
  logic [VERSION_WIDTH-1:0] acc_src;
  logic [ACC_WIDTH-1:0]     acc_sum;
  logic [VERSION_WIDTH-1:0] acc_val;
  status_t                  status_next;
  kind_t                    kind_next;

  assign pop = q_valid && (!result_valid || !result_stall);

  // restart applies before the byte is looked at
  always_comb begin
    st_in  = q_data.start ? PS_METHOD_START : parse_state;
    hs_in  = q_data.start ? 1'b0 : header_seen;
    maj_in = q_data.start ? '0 : major_count;
    min_in = q_data.start ? '0 : minor_count;
  end

  // shared decimal accumulator, saturating
  always_comb begin
    acc_src = (st_in inside {PS_MAJOR_START, PS_MAJOR}) ? maj_in : min_in;
    acc_sum = ACC_WIDTH'({acc_src, 3'b000}) + ACC_WIDTH'({acc_src, 1'b0})
            + ACC_WIDTH'(q_data.value[3:0]);
    acc_val = (acc_sum[ACC_WIDTH-1:VERSION_WIDTH] != '0) ? '1
            : acc_sum[VERSION_WIDTH-1:0];
  end

  always_comb begin
    parse_state_next = st_in;
    header_seen_next = hs_in;
    major_next       = maj_in;
    minor_next       = min_in;
    status_next      = S_MORE;
    kind_next        = K_NONE;
    case (st_in)
      PS_METHOD_START: begin
        if (q_data.tok) begin
          parse_state_next = PS_METHOD;
          kind_next        = K_METHOD;
        end else status_next = S_BAD;
      end
      PS_METHOD: begin
        if (q_data.sp) parse_state_next = PS_URI;
        else if (q_data.tok) kind_next = K_METHOD;
        else status_next = S_BAD;
      end
      PS_URI: begin
        if (q_data.sp) parse_state_next = PS_H;
        else if (q_data.ctl) status_next = S_BAD;
        else kind_next = K_URI;
      end
      PS_H: begin
        if (q_data.ch_h) parse_state_next = PS_T1;
        else status_next = S_BAD;
      end
      PS_T1: begin
        if (q_data.ch_t) parse_state_next = PS_T2;
        else status_next = S_BAD;
      end
      PS_T2: begin
        if (q_data.ch_t) parse_state_next = PS_P;
        else status_next = S_BAD;
      end
      PS_P: begin
        if (q_data.ch_p) parse_state_next = PS_SLASH;
        else status_next = S_BAD;
      end
      PS_SLASH: begin
        if (q_data.slash) begin
          major_next       = '0;
          minor_next       = '0;
          parse_state_next = PS_MAJOR_START;
        end else status_next = S_BAD;
      end
      PS_MAJOR_START: begin
        if (q_data.dig) begin
          major_next       = acc_val;
          parse_state_next = PS_MAJOR;
        end else status_next = S_BAD;
      end
      PS_MAJOR: begin
        if (q_data.dot) parse_state_next = PS_MINOR_START;
        else if (q_data.dig) major_next = acc_val;
        else status_next = S_BAD;
      end
      PS_MINOR_START: begin
        if (q_data.dig) begin
          minor_next       = acc_val;
          parse_state_next = PS_MINOR;
        end else status_next = S_BAD;
      end
      PS_MINOR: begin
        if (q_data.cr) parse_state_next = PS_NL1;
        else if (q_data.dig) minor_next = acc_val;
        else status_next = S_BAD;
      end
      PS_NL1: begin
        if (q_data.lf) parse_state_next = PS_LINE_START;
        else status_next = S_BAD;
      end
      PS_LINE_START: begin
        if (q_data.cr) parse_state_next = PS_NL3;
        else if (hs_in && q_data.ws) parse_state_next = PS_LWS;
        else if (q_data.tok) begin
          header_seen_next = 1'b1;
          kind_next        = K_NEW_NAME;
          parse_state_next = PS_NAME;
        end else status_next = S_BAD;
      end
      PS_LWS: begin
        if (q_data.cr) parse_state_next = PS_NL2;
        else if (q_data.ws) parse_state_next = PS_LWS;
        else if (q_data.ctl) status_next = S_BAD;
        else begin
          kind_next        = K_VALUE;
          parse_state_next = PS_VALUE;
        end
      end
      PS_NAME: begin
        if (q_data.colon) parse_state_next = PS_SPACE_VALUE;
        else if (q_data.tok) kind_next = K_NAME;
        else status_next = S_BAD;
      end
      PS_SPACE_VALUE: begin
        if (q_data.sp) parse_state_next = PS_VALUE;
        else status_next = S_BAD;
      end
      PS_VALUE: begin
        if (q_data.cr) parse_state_next = PS_NL2;
        else if (q_data.ctl) status_next = S_BAD;
        else kind_next = K_VALUE;
      end
      PS_NL2: begin
        if (q_data.lf) parse_state_next = PS_LINE_START;
        else status_next = S_BAD;
      end
      PS_NL3: begin
        status_next = q_data.lf ? S_DONE : S_BAD;
      end
      default: begin
        status_next = S_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= PS_METHOD_START;
      header_seen  <= 1'b0;
      major_count  <= '0;
      minor_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        parse_state  <= parse_state_next;
        header_seen  <= header_seen_next;
        major_count  <= major_next;
        minor_count  <= minor_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status        <= status_next;
      char_kind     <= kind_next;
      char_value    <= (kind_next != K_NONE) ? q_data.value : 8'd0;
      version_major <= VERSION_OUT_WIDTH'(major_next);
      version_minor <= VERSION_OUT_WIDTH'(minor_next);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_header_parser.sv =====
// http request header parser, one request byte per transaction
// an accepted byte is written into the queue, then the parser pops it and registers its result
// throughput: one byte per cycle while result_stall is low, set by the parse state machine
// a two-entry queue sits between the classifying front end and the parser
// reset clears the queue, the parse state, header flag and version counters
// depends on hrp_pkg, hrp_front, hrp_queue, hrp_back and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_header_parser_assert.svh"

module http_request_header_parser #(
  parameter int VERSION_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic        start_req,
  input  wire logic [7:0]  data_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       status,
  output logic [2:0]       char_kind,
  output logic [7:0]       char_value,
  output logic [hrp_pkg::VERSION_OUT_WIDTH-1:0] version_major,
  output logic [hrp_pkg::VERSION_OUT_WIDTH-1:0] version_minor
);
  import hrp_pkg::*;

  logic        push;
  logic        queue_full;
  logic        pop;
  logic        q_valid;
  byte_class_t entry;
  byte_class_t q_data;

  hrp_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .start_req  (start_req),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .push       (push),
    .entry      (entry)
  );

  hrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (queue_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  hrp_back #(
    .VERSION_WIDTH (VERSION_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .char_kind     (char_kind),
    .char_value    (char_value),
    .version_major (version_major),
    .version_minor (version_minor)
  );

  `HRP_ASSERT_NOW(a_bad_no_char, result_valid && (status == S_BAD), char_kind == K_NONE, "malformed byte tagged as character")
  `HRP_ASSERT_NOW(a_none_zero_value, result_valid && (char_kind == K_NONE), char_value == 8'd0, "untagged result carries a byte")
  `HRP_ASSERT_NEXT(a_queue_drains, q_valid && !result_valid, result_valid, "queued byte not taken by idle parser")
  `HRP_ASSERT_NEXT(a_done_on_lf, result_valid && (status == S_DONE) && !result_stall && !q_valid, !result_valid, "result not released")

endmodule

`default_nettype wire
